// ===== design/cdsw_pkg.sv =====
// Shared types and constants of the countdown timer and stopwatch.
package cdsw_pkg;

    typedef enum logic [1:0] {
        MODE_SELECT    = 2'd0,
        MODE_SETUP     = 2'd1,
        MODE_COUNTDOWN = 2'd2,
        MODE_STOPWATCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RUN_STOPPED  = 2'd0,
        RUN_RUNNING  = 2'd1,
        RUN_PAUSED   = 2'd2,
        RUN_FINISHED = 2'd3
    } run_t;

    typedef enum logic [2:0] {
        KEY_UP    = 3'd0,
        KEY_DOWN  = 3'd1,
        KEY_LEFT  = 3'd2,
        KEY_RIGHT = 3'd3,
        KEY_A     = 3'd4,
        KEY_B     = 3'd5,
        KEY_D     = 3'd6,
        KEY_NONE  = 3'd7
    } key_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_BUTTON = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FIELD_HOUR   = 2'd0,
        FIELD_MINUTE = 2'd1,
        FIELD_SECOND = 2'd2
    } field_t;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned TARGET_W  = 27;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
    localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);

    localparam logic [HOUR_W-1:0]   HOUR_RESET   = HOUR_W'(0);
    localparam logic [MINUTE_W-1:0] MINUTE_RESET = MINUTE_W'(5);
    localparam logic [SECOND_W-1:0] SECOND_RESET = SECOND_W'(0);

    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN  = 32'd60;
    localparam logic [31:0] MS_PER_SEC   = 32'd1000;

endpackage

// ===== design/cdsw_if.sv =====
// Valid/ready channel interfaces for the timer's button/tick beats and result beats.
interface cdsw_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [2:0] button;
    logic       pressed;

    modport source (output valid, output operation, output button, output pressed,
                    input ready);
    modport sink (input valid, input operation, input button, input pressed,
                  output ready);
endinterface

interface cdsw_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  run_state;
    logic        menu_choice;
    logic [1:0]  edit_field;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [31:0] elapsed_ms;
    logic [26:0] remaining_ms;
    logic        alarm;
    logic        exit_request;

    modport source (output valid, output mode, output run_state, output menu_choice,
                    output edit_field, output set_hour, output set_minute,
                    output set_second, output elapsed_ms, output remaining_ms,
                    output alarm, output exit_request, input ready);
    modport sink (input valid, input mode, input run_state, input menu_choice,
                  input edit_field, input set_hour, input set_minute,
                  input set_second, input elapsed_ms, input remaining_ms,
                  input alarm, input exit_request, output ready);
endinterface

// ===== design/countdown_stopwatch_timer.sv =====
// Countdown timer and stopwatch: state registers, next-state logic and result register.
//
//   Channel   Dir   Beat contents
//   cmd       in    operation, button, pressed
//   res       out   mode, run_state, menu_choice, edit_field, settings,
//                   elapsed_ms, remaining_ms, alarm, exit_request
//
// Every accepted cmd beat produces one res beat on the following cycle.
// One cmd beat is taken per cycle unless a res beat is stalled; the state update and the result are one register stage.
// A held res beat stalls cmd only when res.ready is low while a beat is waiting.
// Reset (rst_n low, asynchronous) returns select mode, minutes cursor and a 5:00 setting.
module countdown_stopwatch_timer
    import cdsw_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cdsw_cmd_if.sink       cmd,
    cdsw_res_if.source     res
);

    mode_t                  mode_reg,    mode_next;
    run_t                   run_reg,     run_next;
    logic                   menu_reg,    menu_next;
    logic [1:0]             field_reg,   field_next;
    logic [HOUR_W-1:0]      hour_reg,    hour_next;
    logic [MINUTE_W-1:0]    minute_reg,  minute_next;
    logic [SECOND_W-1:0]    second_reg,  second_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [TARGET_W-1:0]    target_reg,  target_next;
    logic                   exit_reg,    exit_next;
    logic                   alarm_next;
    logic [TARGET_W-1:0]    remain_next;

    logic                   res_valid_reg;
    logic [TARGET_W-1:0]    res_remain_reg;
    logic                   res_alarm_reg;

    logic                   accept;
    logic [ELAPSED_W-1:0]   elapsed_inc;
    logic [31:0]            target_calc;
    key_t                   key;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign key       = key_t'(cmd.button);

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign target_calc = 32'(hour_reg) * (SEC_PER_HOUR * MS_PER_SEC)
                       + 32'(minute_reg) * (SEC_PER_MIN * MS_PER_SEC)
                       + 32'(second_reg) * MS_PER_SEC;

    always_comb
    begin
        mode_next    = mode_reg;
        run_next     = run_reg;
        menu_next    = menu_reg;
        field_next   = field_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        elapsed_next = elapsed_reg;
        target_next  = target_reg;
        exit_next    = exit_reg;
        alarm_next   = 1'b0;

        if (op_t'(cmd.operation) == OP_TICK)
        begin
            if (run_reg == RUN_RUNNING)
            begin
                elapsed_next = elapsed_inc;
                if (mode_reg == MODE_COUNTDOWN && elapsed_inc >= ELAPSED_W'(target_reg))
                begin
                    elapsed_next = ELAPSED_W'(target_reg);
                    run_next     = RUN_FINISHED;
                    alarm_next   = 1'b1;
                end
            end
        end
        else if (cmd.pressed)
        begin
            unique case (mode_reg)
                MODE_SELECT:
                begin
                    case (key)
                        KEY_UP:   menu_next = 1'b0;
                        KEY_DOWN: menu_next = 1'b1;
                        KEY_A:
                        begin
                            if (!menu_reg)
                            begin
                                mode_next  = MODE_SETUP;
                                field_next = FIELD_MINUTE;
                            end
                            else
                            begin
                                mode_next    = MODE_STOPWATCH;
                                run_next     = RUN_STOPPED;
                                elapsed_next = '0;
                            end
                        end
                        KEY_B, KEY_D: exit_next = 1'b1;
                        default: ;
                    endcase
                end
                MODE_SETUP:
                begin
                    case (key)
                        KEY_LEFT:
                        begin
                            if (field_reg != FIELD_HOUR)
                                field_next = field_reg - 1'b1;
                        end
                        KEY_RIGHT:
                        begin
                            if (field_reg < FIELD_SECOND)
                                field_next = field_reg + 1'b1;
                        end
                        KEY_UP:
                        begin
                            if (field_reg == FIELD_HOUR)
                                hour_next = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 1'b1;
                            else if (field_reg == FIELD_MINUTE)
                                minute_next = (minute_reg >= MINUTE_MAX) ? '0
                                                                         : minute_reg + 1'b1;
                            else
                                second_next = (second_reg >= SECOND_MAX) ? '0
                                                                         : second_reg + 1'b1;
                        end
                        KEY_DOWN:
                        begin
                            if (field_reg == FIELD_HOUR)
                                hour_next = (hour_reg == '0) ? HOUR_MAX : hour_reg - 1'b1;
                            else if (field_reg == FIELD_MINUTE)
                                minute_next = (minute_reg == '0) ? MINUTE_MAX
                                                                 : minute_reg - 1'b1;
                            else
                                second_next = (second_reg == '0) ? SECOND_MAX
                                                                 : second_reg - 1'b1;
                        end
                        KEY_A:
                        begin
                            target_next = target_calc[TARGET_W-1:0];
                            if (target_calc[TARGET_W-1:0] != '0)
                            begin
                                mode_next    = MODE_COUNTDOWN;
                                run_next     = RUN_RUNNING;
                                elapsed_next = '0;
                            end
                        end
                        KEY_B: mode_next = MODE_SELECT;
                        default: ;
                    endcase
                end
                MODE_COUNTDOWN, MODE_STOPWATCH:
                begin
                    case (key)
                        KEY_A:
                        begin
                            if (run_reg == RUN_RUNNING)
                                run_next = RUN_PAUSED;
                            else if (run_reg == RUN_PAUSED)
                                run_next = RUN_RUNNING;
                            else if (run_reg == RUN_STOPPED && mode_reg == MODE_STOPWATCH)
                                run_next = RUN_RUNNING;
                            else if (run_reg == RUN_FINISHED && mode_reg == MODE_COUNTDOWN)
                            begin
                                run_next     = RUN_STOPPED;
                                elapsed_next = '0;
                                mode_next    = MODE_SETUP;
                            end
                        end
                        KEY_B:
                        begin
                            if (run_reg == RUN_RUNNING || run_reg == RUN_PAUSED)
                            begin
                                run_next     = RUN_STOPPED;
                                elapsed_next = '0;
                            end
                            else
                                mode_next = MODE_SELECT;
                        end
                        KEY_D:
                        begin
                            run_next     = RUN_STOPPED;
                            elapsed_next = '0;
                            mode_next    = MODE_SELECT;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        remain_next = (elapsed_next < ELAPSED_W'(target_next))
                    ? target_next - elapsed_next[TARGET_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SELECT;
            run_reg       <= RUN_STOPPED;
            menu_reg      <= 1'b0;
            field_reg     <= FIELD_MINUTE;
            hour_reg      <= HOUR_RESET;
            minute_reg    <= MINUTE_RESET;
            second_reg    <= SECOND_RESET;
            elapsed_reg   <= '0;
            target_reg    <= '0;
            exit_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                run_reg     <= run_next;
                menu_reg    <= menu_next;
                field_reg   <= field_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                elapsed_reg <= elapsed_next;
                target_reg  <= target_next;
                exit_reg    <= exit_next;
            end
            if (accept)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_remain_reg <= remain_next;
            res_alarm_reg  <= alarm_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.mode         = mode_reg;
    assign res.run_state    = run_reg;
    assign res.menu_choice  = menu_reg;
    assign res.edit_field   = field_reg;
    assign res.set_hour     = hour_reg;
    assign res.set_minute   = minute_reg;
    assign res.set_second   = second_reg;
    assign res.elapsed_ms   = elapsed_reg;
    assign res.remaining_ms = res_remain_reg;
    assign res.alarm        = res_alarm_reg;
    assign res.exit_request = exit_reg;

    a_alarm_finish: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_alarm_reg |->
            run_reg == RUN_FINISHED && mode_reg == MODE_COUNTDOWN && res_remain_reg == '0)
        else $error("alarm without a finished countdown");

    a_countdown_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_COUNTDOWN |-> elapsed_reg <= ELAPSED_W'(target_reg))
        else $error("countdown elapsed time beyond its target");

    a_exit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        exit_reg |=> exit_reg)
        else $error("exit request cleared");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg != 2'd3)
        else $error("setup cursor out of range");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !accept)
        else $error("beat accepted while a result is stalled");

endmodule

// ===== dv/timer_result_checker.sv =====
// Checker that predicts every result beat of the countdown timer and stopwatch and compares it.
module timer_result_checker
    import cdsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cdsw_cmd_if         cmd,
    cdsw_res_if         res,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        mode_t       mode;
        run_t        run_state;
        logic        menu_choice;
        field_t      edit_field;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic [31:0] elapsed_ms;
        logic [26:0] remaining_ms;
        logic        alarm;
        logic        exit_request;
    } timer_view_t;

    timer_view_t expected_views[$];

    mode_t       cur_mode;
    run_t        cur_run;
    logic        cur_menu;
    field_t      cur_field;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [31:0] elapsed;
    logic [26:0] target;
    logic        exit_seen;

    function automatic void clear_run();
        cur_run = RUN_STOPPED;
        elapsed = '0;
    endfunction

    function automatic void adjust_setting(input logic up);
        case (cur_field)
            FIELD_HOUR:
                hours = 5'((32'(hours) + (up ? 32'd1 : 32'd23)) % 32'd24);
            FIELD_MINUTE:
                minutes = 6'((32'(minutes) + (up ? 32'd1 : 32'd59)) % 32'd60);
            default:
                seconds = 6'((32'(seconds) + (up ? 32'd1 : 32'd59)) % 32'd60);
        endcase
    endfunction

    function automatic void press_in_run(input key_t key);
        if (key == KEY_A) begin
            if (cur_run == RUN_RUNNING)
                cur_run = RUN_PAUSED;
            else if (cur_run == RUN_PAUSED)
                cur_run = RUN_RUNNING;
            else if (cur_run == RUN_STOPPED && cur_mode == MODE_STOPWATCH)
                cur_run = RUN_RUNNING;
            else if (cur_run == RUN_FINISHED && cur_mode == MODE_COUNTDOWN)
            begin
                clear_run();
                cur_mode = MODE_SETUP;
            end
        end
        else if (key == KEY_B) begin
            if (cur_run == RUN_RUNNING || cur_run == RUN_PAUSED)
                clear_run();
            else
                cur_mode = MODE_SELECT;
        end
        else if (key == KEY_D) begin
            clear_run();
            cur_mode = MODE_SELECT;
        end
    endfunction

    function automatic void press_key(input key_t key);
        logic [31:0] total_ms;
        case (cur_mode)
            MODE_SELECT: begin
                if (key == KEY_UP && cur_menu)
                    cur_menu = 1'b0;
                else if (key == KEY_DOWN && !cur_menu)
                    cur_menu = 1'b1;
                else if (key == KEY_A) begin
                    if (!cur_menu) begin
                        cur_mode  = MODE_SETUP;
                        cur_field = FIELD_MINUTE;
                    end
                    else begin
                        cur_mode = MODE_STOPWATCH;
                        clear_run();
                    end
                end
                else if (key == KEY_B || key == KEY_D)
                    exit_seen = 1'b1;
            end
            MODE_SETUP: begin
                if (key == KEY_LEFT && cur_field != FIELD_HOUR)
                    cur_field = field_t'(cur_field - 2'd1);
                else if (key == KEY_RIGHT && cur_field < FIELD_SECOND)
                    cur_field = field_t'(cur_field + 2'd1);
                else if (key == KEY_UP)
                    adjust_setting(1'b1);
                else if (key == KEY_DOWN)
                    adjust_setting(1'b0);
                else if (key == KEY_A) begin
                    total_ms = (32'(hours) * SEC_PER_HOUR + 32'(minutes) * SEC_PER_MIN
                                + 32'(seconds)) * MS_PER_SEC;
                    target = total_ms[26:0];
                    if (target != '0) begin
                        cur_mode = MODE_COUNTDOWN;
                        cur_run  = RUN_RUNNING;
                        elapsed  = '0;
                    end
                end
                else if (key == KEY_B)
                    cur_mode = MODE_SELECT;
            end
            default:
                press_in_run(key);
        endcase
    endfunction

    function automatic timer_view_t step_timer(input op_t op, input key_t key,
                                               input logic pr);
        timer_view_t view;
        view.alarm = 1'b0;
        if (op == OP_TICK) begin
            if (cur_run == RUN_RUNNING) begin
                if (elapsed != '1)
                    elapsed = elapsed + 32'd1;
                if (cur_mode == MODE_COUNTDOWN && elapsed >= {5'd0, target}) begin
                    elapsed    = {5'd0, target};
                    cur_run    = RUN_FINISHED;
                    view.alarm = 1'b1;
                end
            end
        end
        else if (pr) begin
            press_key(key);
        end
        view.mode         = cur_mode;
        view.run_state    = cur_run;
        view.menu_choice  = cur_menu;
        view.edit_field   = cur_field;
        view.set_hour     = hours;
        view.set_minute   = minutes;
        view.set_second   = seconds;
        view.elapsed_ms   = elapsed;
        view.remaining_ms = (elapsed < {5'd0, target}) ? 27'({5'd0, target} - elapsed) : '0;
        view.exit_request = exit_seen;
        return view;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        timer_view_t want;
        if (!rst_n) begin
            cur_mode    = MODE_SELECT;
            cur_run     = RUN_STOPPED;
            cur_menu    = 1'b0;
            cur_field   = FIELD_MINUTE;
            hours       = HOUR_RESET;
            minutes     = MINUTE_RESET;
            seconds     = SECOND_RESET;
            elapsed     = '0;
            target      = '0;
            exit_seen   = 1'b0;
            mismatches  = 0;
            outstanding = 0;
            expected_views.delete();
        end
        else begin
            if (res.valid && res.ready) begin
                if (expected_views.size() == 0) begin
                    $error("Result beat arrived with no command beat waiting for it.");
                    mismatches++;
                end
                else begin
                    want = expected_views.pop_front();
                    check_field("mode", want.mode, res.mode);
                    check_field("run_state", want.run_state, res.run_state);
                    check_field("menu_choice", want.menu_choice, res.menu_choice);
                    check_field("edit_field", want.edit_field, res.edit_field);
                    check_field("set_hour", want.set_hour, res.set_hour);
                    check_field("set_minute", want.set_minute, res.set_minute);
                    check_field("set_second", want.set_second, res.set_second);
                    check_field("elapsed_ms", want.elapsed_ms, res.elapsed_ms);
                    check_field("remaining_ms", want.remaining_ms, res.remaining_ms);
                    check_field("alarm", want.alarm, res.alarm);
                    check_field("exit_request", want.exit_request, res.exit_request);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_views.push_back(step_timer(op_t'(cmd.operation),
                                                    key_t'(cmd.button), cmd.pressed));
            outstanding = expected_views.size();
        end
    end

endmodule

// ===== dv/countdown_stopwatch_timer_tb.sv =====
// Top of the countdown timer and stopwatch testbench: clock, reset, stimulus and verdict.
module countdown_stopwatch_timer_tb;
    import cdsw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIRECTED_BEATS = 24;
    localparam int unsigned RANDOM_BEATS   = 50;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned beats_sent = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    cdsw_cmd_if cmd_ch ();
    cdsw_res_if res_ch ();

    countdown_stopwatch_timer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    timer_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        res_ch.ready <= (cycle_count >= 500 && cycle_count < 800) ||
                        ($urandom_range(99) >= 10);
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_beat(input op_t op, input key_t key, input logic pr);
        while (!(beats_sent >= 400 && beats_sent < 700) && $urandom_range(99) < 10)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.button    <= key;
        cmd_ch.pressed   <= pr;
        @(negedge clk);
        while (!cmd_ch.ready)
            @(negedge clk);
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic press(input key_t key);
        send_beat(OP_BUTTON, key, 1'b1);
    endtask

    task automatic tick();
        send_beat(OP_TICK, key_t'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic release_key();
        send_beat(OP_BUTTON, key_t'($urandom_range(7)), 1'b0);
    endtask

    function automatic key_t stray_key();
        int unsigned pick;
        pick = $urandom_range(4);
        return (pick == 4) ? KEY_NONE : key_t'(pick);
    endfunction

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic go_home();
        press(KEY_D);
        press(KEY_B);
    endtask

    task automatic enter_setup();
        go_home();
        press(KEY_UP);
        press(KEY_A);
    endtask

    task automatic enter_stopwatch();
        go_home();
        press(KEY_DOWN);
        press(KEY_A);
    endtask

    task automatic step_setting(input int cur, input int want, input int modulus);
        int diff;
        diff = (want - cur + modulus) % modulus;
        if (diff <= modulus / 2)
            repeat (diff) press(KEY_UP);
        else
            repeat (modulus - diff) press(KEY_DOWN);
    endtask

    // Expects setup mode; two left presses bring the cursor to hours from anywhere.
    task automatic dial_setting(input int want_h, input int want_m, input int want_s);
        int cur_h;
        int cur_m;
        int cur_s;
        wait_drained();
        @(negedge clk);
        cur_h = int'(res_ch.set_hour);
        cur_m = int'(res_ch.set_minute);
        cur_s = int'(res_ch.set_second);
        @(posedge clk);
        repeat (2) press(KEY_LEFT);
        step_setting(cur_h, want_h, 24);
        press(KEY_RIGHT);
        step_setting(cur_m, want_m, 60);
        press(KEY_RIGHT);
        step_setting(cur_s, want_s, 60);
    endtask

    task automatic run_session(input int unsigned beats);
        int unsigned pick;
        repeat (beats)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                tick();
            else if (pick < 83)
                press(KEY_A);
            else if (pick < 87)
                press(KEY_B);
            else if (pick < 95)
                press(stray_key());
            else
                release_key();
        end
    endtask

    task automatic setup_session();
        int unsigned pick;
        enter_setup();
        repeat ($urandom_range(4, 16))
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                press(key_t'($urandom_range(3)));
            else if (pick < 90)
                press(KEY_NONE);
            else if (pick < 95)
                press(KEY_D);
            else
                release_key();
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            press(KEY_B);
        end
        else if (pick == 1) begin
            dial_setting(23, 59, 59);
            press(KEY_A);
            run_session($urandom_range(5, 30));
            press(KEY_D);
        end
        else if (pick == 2) begin
            dial_setting(0, 0, 0);
            press(KEY_A);
            press(KEY_B);
        end
        else begin
            if (pick == 3)
                dial_setting($urandom_range(23), $urandom_range(59), $urandom_range(59));
            press(KEY_A);
            run_session($urandom_range(5, 40));
            press($urandom_range(1) ? KEY_D : KEY_B);
        end
    endtask

    task automatic stopwatch_session();
        enter_stopwatch();
        if ($urandom_range(3) != 0)
            press(KEY_A);
        run_session($urandom_range(5, 60));
        press($urandom_range(1) ? KEY_D : KEY_B);
    endtask

    task automatic countdown_to_alarm();
        int unsigned run_ms;
        int unsigned pick;
        enter_setup();
        dial_setting(0, 0, 1);
        press(KEY_A);
        run_ms = 0;
        while (run_ms < 1003)
        begin
            pick = $urandom_range(99);
            if (pick < 1 && run_ms < 990) begin
                press(KEY_A);
                repeat ($urandom_range(1, 5)) tick();
                press(KEY_A);
            end
            else if (pick < 3) begin
                if ($urandom_range(1))
                    press(stray_key());
                else
                    release_key();
            end
            else begin
                tick();
                run_ms++;
            end
        end
        press($urandom_range(1) ? KEY_A : KEY_B);
        repeat ($urandom_range(1, 4)) tick();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_TICK;
        cmd_ch.button    = KEY_UP;
        cmd_ch.pressed   = 1'b0;
        res_ch.ready     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Idle tick, a release, the unused key code and menu cursor limits.
        send_beat(OP_TICK, KEY_A, 1'b1);
        send_beat(OP_BUTTON, KEY_A, 1'b0);
        press(KEY_NONE);
        press(KEY_DOWN);
        press(KEY_DOWN);
        press(KEY_UP);
        press(KEY_B);
        press(KEY_A);
        // Field cursor limits, wrap of hours and seconds in both directions, minutes down to zero.
        press(KEY_RIGHT);
        press(KEY_RIGHT);
        press(KEY_DOWN);
        press(KEY_UP);
        press(KEY_LEFT);
        press(KEY_LEFT);
        press(KEY_LEFT);
        press(KEY_DOWN);
        press(KEY_UP);
        press(KEY_RIGHT);
        repeat (5) press(KEY_DOWN);
        // All settings are zero now, so start has no effect.
        press(KEY_A);

        while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS)
        begin
            case ($urandom_range(4))
                0: repeat ($urandom_range(1, 6))
                       send_beat(op_t'($urandom_range(1)), key_t'($urandom_range(7)),
                                 1'($urandom_range(1)));
                1: repeat ($urandom_range(2, 6))
                       if ($urandom_range(5) == 0)
                           release_key();
                       else
                           press(key_t'($urandom_range(1)) == KEY_UP ?
                                 stray_key() : ($urandom_range(1) ? KEY_B : KEY_D));
                2: setup_session();
                3: stopwatch_session();
                default: setup_session();
            endcase
        end
        countdown_to_alarm();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
